@@ hdl/w3sf_pkg.sv @@
// Shared constants and widths for the weighted 3x3 smoothing filter.
package w3sf_pkg;

  // Fixed field widths
  localparam int PIXEL_W    = 8;
  localparam int OUT_COL_W  = 10;
  localparam int ROW_W      = 16;
  localparam int IMG_W_BITS = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Defaults and register reset values
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0]      HEIGHT_RESET = 16'd480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  // Weighted sum peaks at 7140; divide by 28 as (sum >> 2) * ceil(2^16 / 7) >> 16
  localparam int SUM_W       = 13;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_SEVEN = 14'd9363;
  localparam int PROD_W      = SUM_W - 2 + RECIP_W;

endpackage

@@ hdl/w3sf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module w3sf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/weighted_3x3_smoothing_filter.sv @@
// Top level of the weighted 3x3 smoothing filter with line store and window.
//
//  channel   direction  handshake                 payload
//  pixel     in         pixel_valid/pixel_ready   pixel
//  result    out        result_valid/result_ready out_column, out_row, value, frame_end
//  config    in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One pixel per clock sustained while results are taken; a pixel passes the line store
// read at the accepting edge, then the window shift, the weighted sum and the reciprocal
// multiply before its result shows on result_valid.
// The line store is one 16-bit RAM row per column holding the two previous rows,
// read and written once per pixel; no clearing pass follows reset.
// Reset clears counters, window and stage valids, and loads 640 x 480.
// A stalled result holds the output register; back-pressure moves upstream only as
// far as stages are full, so bubbles are squeezed out and pixel_ready drops only when
// all four stages hold a transaction and the result waits.
module weighted_3x3_smoothing_filter #(
  parameter int MAX_WIDTH = w3sf_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [w3sf_pkg::PIXEL_W-1:0]    pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [w3sf_pkg::OUT_COL_W-1:0]  out_column,
  output logic [w3sf_pkg::ROW_W-1:0]      out_row,
  output logic [w3sf_pkg::PIXEL_W-1:0]    value,
  output logic                            frame_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [w3sf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [w3sf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import w3sf_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
  localparam int LW   = 2 * PIXEL_W;

  // Configuration registers
  logic [IMG_W_BITS-1:0] image_width;
  logic [ROW_W-1:0]      image_height;

  // Position counters
  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  // Position decode
  logic [WCMP-1:0]  width_raw, eff_width, x_ext;
  logic [ROW_W-1:0] eff_height;
  logic             last_col, last_row, emit, at_end;
  logic [CW-1:0]    x_minus;
  logic [ROW_W-1:0] y_minus;

  // Stage handshake
  logic accept, adv1, adv2, adv3, adv_out;

  // Stage 1: line store read in flight
  logic                 s1_valid, s1_emit, s1_end;
  logic [PIXEL_W-1:0]   s1_pixel;
  logic [CW-1:0]        s1_addr;
  logic [OUT_COL_W-1:0] s1_column;
  logic [ROW_W-1:0]     s1_row;
  logic [LW-1:0]        line_rdata;

  // Stage 2: window
  logic                 s2_valid, s2_end;
  logic [OUT_COL_W-1:0] s2_column;
  logic [ROW_W-1:0]     s2_row;
  logic [PIXEL_W-1:0]   win [3][3];

  // Stage 3: weighted sum
  logic                 s3_valid, s3_end;
  logic [OUT_COL_W-1:0] s3_column;
  logic [ROW_W-1:0]     s3_row;
  logic [SUM_W-1:0]     s3_sum;
  logic [SUM_W-1:0]     sum_next;
  logic [PIXEL_W+1:0]   corners, edges;
  logic [PROD_W-1:0]    quot_prod;

  assign cfg_ready = 1'b1;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate frame size
  assign width_raw = WCMP'(image_width);
  always_comb begin
    if (width_raw < WCMP'(3)) begin
      eff_width = WCMP'(3);
    end else if (width_raw > WCMP'(MAX_WIDTH)) begin
      eff_width = WCMP'(MAX_WIDTH);
    end else begin
      eff_width = width_raw;
    end
  end
  assign eff_height = (image_height < ROW_W'(3)) ? ROW_W'(3) : image_height;

  // Decode position of the incoming pixel
  assign x_ext    = WCMP'(column_count);
  assign last_col = x_ext >= eff_width - WCMP'(1);
  assign last_row = row_count >= eff_height - ROW_W'(1);
  assign emit     = (x_ext >= WCMP'(2)) && (row_count >= ROW_W'(2)) &&
                    (x_ext < eff_width) && (row_count < eff_height);
  assign at_end   = (x_ext == eff_width - WCMP'(1)) && (row_count == eff_height - ROW_W'(1));
  assign x_minus  = column_count - CW'(1);
  assign y_minus  = row_count - ROW_W'(1);

  // Advance counters
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Ready chain: a stage loads when it is empty or its contents move on
  assign adv_out     = !result_valid || result_ready;
  assign adv3        = !s3_valid || adv_out;
  assign adv2        = !s2_valid || adv3;
  assign adv1        = !s1_valid || adv2;
  assign pixel_ready = adv1;
  assign accept      = pixel_valid && pixel_ready;

  // Line store: low byte is the row above, high byte the row two above
  w3sf_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid && adv2),
    .waddr (s1_addr),
    .wdata ({line_rdata[PIXEL_W-1:0], s1_pixel}),
    .re    (accept),
    .raddr (column_count),
    .rdata (line_rdata)
  );

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel;
      s1_addr   <= column_count;
      s1_emit   <= emit;
      s1_end    <= at_end;
      s1_column <= OUT_COL_W'(x_minus);
      s1_row    <= y_minus;
    end
  end

  // Shift window by one column as each pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (s1_valid && adv2) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= line_rdata[LW-1:PIXEL_W];
      win[1][2] <= line_rdata[PIXEL_W-1:0];
      win[2][2] <= s1_pixel;
    end
  end

  // Stage 2: only interior pixels carry on
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_column <= s1_column;
      s2_row    <= s1_row;
      s2_end    <= s1_end;
    end
  end

  // Weighted sum: corners x1, edges x4, center x8
  always_comb begin
    corners  = (PIXEL_W+2)'(win[0][0]) + (PIXEL_W+2)'(win[0][2]) +
               (PIXEL_W+2)'(win[2][0]) + (PIXEL_W+2)'(win[2][2]);
    edges    = (PIXEL_W+2)'(win[0][1]) + (PIXEL_W+2)'(win[1][0]) +
               (PIXEL_W+2)'(win[1][2]) + (PIXEL_W+2)'(win[2][1]);
    sum_next = SUM_W'(corners) + SUM_W'({edges, 2'b00}) + SUM_W'({win[1][1], 3'b000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_sum    <= sum_next;
      s3_column <= s2_column;
      s3_row    <= s2_row;
      s3_end    <= s2_end;
    end
  end

  // Divide by 28 through the reciprocal of 7
  assign quot_prod = PROD_W'(s3_sum[SUM_W-1:2]) * PROD_W'(RECIP_SEVEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s3_valid) begin
      value      <= quot_prod[RECIP_SHIFT +: PIXEL_W];
      out_column <= s3_column;
      out_row    <= s3_row;
      frame_end  <= s3_end;
    end
  end

endmodule

@@ hdl/w3sf_check.sv @@
// Port-level checks for the weighted 3x3 smoothing filter, bound to the top level.
module w3sf_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            pixel_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [w3sf_pkg::OUT_COL_W-1:0]  out_column,
  input logic [w3sf_pkg::ROW_W-1:0]      out_row,
  input logic [w3sf_pkg::PIXEL_W-1:0]    value,
  input logic                            frame_end
);

  import w3sf_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  // A stalled result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_column) &&
    $stable(out_row) && $stable(value) && $stable(frame_end))
    else $error("stalled result changed");

  // With the output free, the pipeline never pushes back on pixels
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid || result_ready |-> pixel_ready)
    else $error("pixel_ready low with free output");

  // Only interior pixels come out
  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> out_column != '0 && out_row != '0)
    else $error("border pixel emitted");

endmodule

bind weighted_3x3_smoothing_filter w3sf_check u_w3sf_check (.*);
